>>> design/bdh_pkg.sv
// ----------------------------------------------------------------------------
// bdh_pkg
// Shared types and constants for the debounced button event block.
// ----------------------------------------------------------------------------
package bdh_pkg;

  localparam int TIME_WIDTH = 16;
  localparam int CFG_WIDTH  = 16;
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_HOLD     = 2'd1,
    REG_INVERT   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    SW_OFF        = 2'd0,
    SW_ON         = 2'd1,
    SW_DEBOUNCING = 2'd2
  } sw_state_t;

  typedef enum logic [1:0] {
    EV_IDLE  = 2'd0,
    EV_PRESS = 2'd1,
    EV_CLICK = 2'd2,
    EV_HOLD  = 2'd3
  } ev_t;

  // Events caused by one tick: one or two of them.
  typedef struct packed {
    ev_t  ev0;
    ev_t  ev1;
    logic two;
  } grp_t;

endpackage

>>> design/button_debounce_hold_events.sv
// ----------------------------------------------------------------------------
// button_debounce_hold_events
// Debounced push button that reports press, click, hold and idle events.
// ----------------------------------------------------------------------------
// Each input beat on in_valid/in_stall is one millisecond tick with the raw
// switch level. The block emits zero, one or two events per tick on the
// out_valid/out_stall channel; last_of_run marks the last event of a tick.
// Registers debounce_ticks, hold_ticks and invert_input are written through
// wr_en, wr_index and wr_data; the user must do so only while the block is
// idle, as the block itself does not enforce it. A new tick can be taken
// every cycle while in_stall is low. Its first event passes through the
// queue and then the output register, and out_stall can hold it back further.
// The output stage sends one event per cycle while out_stall is low, so a tick
// with two events holds the output for both; a four-entry queue of event groups absorbs this.
// in_stall rises only when that queue is full.
// When out_stall is high the current event holds and ticks keep entering
// until the queue fills.
// Reset restores the register defaults, clears the queue and puts the
// switch in the released, idle state.
// ----------------------------------------------------------------------------
module button_debounce_hold_events (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [1:0]                    wr_index,
  input  logic [bdh_pkg::CFG_WIDTH-1:0] wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          raw_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    event_code,
  output logic                          last_of_run
);
  import bdh_pkg::*;

  logic tick, push, pop, empty, full;
  grp_t grp, head;

  assign in_stall = full;
  assign tick     = in_valid && !full;

  bdh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .tick      (tick),
    .raw_level (raw_level),
    .push      (push),
    .grp       (grp)
  );

  bdh_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (grp),
    .pop   (pop),
    .rdata (head),
    .empty (empty),
    .full  (full)
  );

  bdh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_code  (event_code),
    .last_of_run (last_of_run)
  );

endmodule

>>> design/bdh_front.sv
// ----------------------------------------------------------------------------
// bdh_front
// Configuration registers, debounce and event state, and event grouping.
// ----------------------------------------------------------------------------
module bdh_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [1:0]                    wr_index,
  input  logic [bdh_pkg::CFG_WIDTH-1:0] wr_data,
  input  logic                          tick,
  input  logic                          raw_level,
  output logic                          push,
  output bdh_pkg::grp_t                 grp
);
  import bdh_pkg::*;

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  logic [CFG_WIDTH-1:0]  debounce_ticks;
  logic [CFG_WIDTH-1:0]  hold_ticks;
  logic                  invert_input;
  sw_state_t             sw, sw_next;
  ev_t                   bev, bev_next;
  logic [TIME_WIDTH-1:0] elapsed, elapsed_next;

  logic level, win_open, acc, hold_hit, click_idle;
  ev_t  ev_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= CFG_WIDTH'(50);
      hold_ticks     <= CFG_WIDTH'(1000);
      invert_input   <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEBOUNCE: debounce_ticks <= wr_data;
        REG_HOLD:     hold_ticks     <= wr_data;
        REG_INVERT:   invert_input   <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sw_state_t sw_mid;
    ev_t       bev_mid;
    logic [TIME_WIDTH-1:0] el_inc;
    level      = raw_level ^ invert_input;
    el_inc     = (elapsed == TIME_MAX) ? elapsed : elapsed + 1'b1;
    win_open   = (sw != SW_DEBOUNCING) && (level != (sw == SW_ON));
    elapsed_next = win_open ? '0 : el_inc;
    sw_mid     = win_open ? SW_DEBOUNCING : sw;
    acc        = (sw_mid == SW_DEBOUNCING) &&
                 ({{(32-TIME_WIDTH){1'b0}}, elapsed_next} >=
                  {{(32-CFG_WIDTH){1'b0}}, debounce_ticks});
    sw_next    = sw_mid;
    bev_mid    = bev;
    ev_acc     = EV_IDLE;
    if (acc) begin
      if (level) begin
        sw_next = SW_ON;
        bev_mid = EV_PRESS;
        ev_acc  = EV_PRESS;
      end else begin
        sw_next = SW_OFF;
        if (bev == EV_PRESS) begin
          bev_mid = EV_CLICK;
          ev_acc  = EV_CLICK;
        end else begin
          bev_mid = EV_IDLE;
          ev_acc  = EV_IDLE;
        end
      end
    end
    hold_hit   = (bev_mid == EV_PRESS) &&
                 ({{(32-TIME_WIDTH){1'b0}}, elapsed_next} >=
                  {{(32-CFG_WIDTH){1'b0}}, hold_ticks});
    click_idle = (bev_mid == EV_CLICK);
    bev_next   = bev_mid;
    if (hold_hit) begin
      bev_next = EV_HOLD;
    end else if (click_idle) begin
      bev_next = EV_IDLE;
    end
  end

  always_comb begin
    push    = tick && (acc || hold_hit);
    grp.ev0 = acc ? ev_acc : EV_HOLD;
    grp.ev1 = hold_hit ? EV_HOLD : EV_IDLE;
    grp.two = acc && (hold_hit || click_idle);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw      <= SW_OFF;
      bev     <= EV_IDLE;
      elapsed <= '0;
    end else if (tick) begin
      sw      <= sw_next;
      bev     <= bev_next;
      elapsed <= elapsed_next;
    end
  end

`ifndef SYNTHESIS
  a_on_pressed: assert property (@(posedge clk) disable iff (rst)
    (sw == SW_ON) |-> (bev == EV_PRESS || bev == EV_HOLD))
    else $error("switch on without a press or hold state");
  a_off_idle: assert property (@(posedge clk) disable iff (rst)
    (sw == SW_OFF) |-> (bev == EV_IDLE))
    else $error("switch off without idle state");
`endif

endmodule

>>> design/bdh_fifo.sv
// ----------------------------------------------------------------------------
// bdh_fifo
// Short queue of event groups between the front and the output stage.
// ----------------------------------------------------------------------------
module bdh_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bdh_pkg::grp_t wdata,
  input  logic          pop,
  output bdh_pkg::grp_t rdata,
  output logic          empty,
  output logic          full
);
  import bdh_pkg::*;

  grp_t           mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QAW+1)'(QDEPTH));
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue written while full");
`endif

endmodule

>>> design/bdh_back.sv
// ----------------------------------------------------------------------------
// bdh_back
// Output stage: takes event groups from the queue and sends one event a beat.
// ----------------------------------------------------------------------------
module bdh_back (
  input  logic          clk,
  input  logic          rst,
  input  bdh_pkg::grp_t head,
  input  logic          empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    event_code,
  output logic          last_of_run
);
  import bdh_pkg::*;

  grp_t cur;
  logic sel;
  logic fire, load;

  assign fire        = out_valid && !out_stall;
  assign load        = !out_valid || (fire && !(cur.two && !sel));
  assign pop         = load && !empty;
  assign event_code  = sel ? cur.ev1 : cur.ev0;
  assign last_of_run = !cur.two || sel;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      sel       <= 1'b0;
    end else if (fire) begin
      sel <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_sel_two: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sel) |-> cur.two)
    else $error("second event selected for a single-event group");
`endif

endmodule
